[hdl/radix_digit_emitter_macros.svh]
// Assertion macros for the radix digit emitter.
// Used by the RTL modules that carry concurrent checks; no other dependencies.
`ifndef RADIX_DIGIT_EMITTER_MACROS_SVH
`define RADIX_DIGIT_EMITTER_MACROS_SVH

`ifndef SYNTHESIS
// Check that holds at every clock edge outside reset.
`define RDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define RDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RDE_ASSERT(lbl, prop, msg)
`define RDE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hdl/rde_pkg.sv]
// Shared types, constants and the digit-to-ASCII function of the radix digit emitter.
// No dependencies.
package rde_pkg;

  localparam int VALUE_W   = 32;  // width of the value field
  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int STEP_BITS = 8;   // quotient bits resolved per divider cycle

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO     = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A  = 7'd97;
  localparam logic [CHAR_W-1:0] DECIMAL_DIGITS = 7'd10;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } bk_state_t;

  // digits 0..9 -> '0'..'9', 10..35 -> 'a'..'z'
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d7;
    d7 = {1'b0, d};
    if (d7 < DECIMAL_DIGITS) begin
      return d7 + ASCII_ZERO;
    end else begin
      return d7 - DECIMAL_DIGITS + ASCII_LOWER_A;
    end
  endfunction

endpackage

[hdl/rde_front.sv]
// Front end: takes input beats, trims the value to the working width, flags zero.
// Depends on rde_pkg.
module rde_front import rde_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_W-1:0]    value,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [VALUE_BITS-1:0] push_value,
  output logic                  push_zero
);

  logic                  f_valid;
  logic [VALUE_BITS-1:0] f_value;
  logic                  f_zero;
  logic [VALUE_BITS-1:0] trimmed;

  assign trimmed  = VALUE_BITS'(value);
  assign in_ready = !f_valid || push_ready;

  // beat holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_value <= trimmed;
      f_zero  <= (trimmed == '0);
    end
  end

  assign push_valid = f_valid;
  assign push_value = f_value;
  assign push_zero  = f_zero;

endmodule

[hdl/rde_queue.sv]
// Two-entry queue between the front end and the conversion back end.
// Depends on rde_pkg.
module rde_queue import rde_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  logic [VALUE_BITS-1:0] push_value,
  input  logic                  push_zero,
  input  logic                  pop,
  output logic                  head_valid,
  output logic [VALUE_BITS-1:0] head_value,
  output logic                  head_zero
);

  logic [VALUE_BITS-1:0] q_value [2];
  logic                  q_zero  [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_value[wr_ptr] <= push_value;
      q_zero[wr_ptr]  <= push_zero;
    end
  end

  assign head_value = q_value[rd_ptr];
  assign head_zero  = q_zero[rd_ptr];

endmodule

[hdl/rde_divider.sv]
// Iterative divider by the radix: STEP_BITS restoring steps per cycle.
// Depends on rde_pkg.
module rde_divider import rde_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    radix,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [RADIX_W-1:0]    remainder
);

  localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W = STEPS * STEP_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] work;
  logic [DIV_W-1:0] work_next;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W-1:0] rem_next;

  // per busy cycle: shift STEP_BITS dividend bits into the remainder, quotient bits in at the bottom
  always_comb begin
    logic [RADIX_W:0] t;
    work_next = work;
    rem_next  = rem;
    for (int i = 0; i < STEP_BITS; i++) begin
      t         = {rem_next, work_next[DIV_W-1]};
      work_next = {work_next[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, radix}) begin
        t            = t - {1'b0, radix};
        work_next[0] = 1'b1;
      end
      rem_next = t[RADIX_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      work <= DIV_W'(dividend);
      rem  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign quotient  = work[VALUE_BITS-1:0];
  assign remainder = rem;

endmodule

[hdl/rde_back.sv]
// Back end: divides by the radix into a digit stack, then pops it most significant first.
// Depends on rde_pkg, rde_divider and the assertion macros.
`include "radix_digit_emitter_macros.svh"
module rde_back import rde_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [RADIX_W-1:0]    radix,
  input  logic                  q_valid,
  input  logic [VALUE_BITS-1:0] q_value,
  input  logic                  q_zero,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     digit_char,
  output logic                  last
);

  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int SP_W  = $clog2(VALUE_BITS + 1);

  bk_state_t state;
  bk_state_t state_next;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;

  logic [RADIX_W-1:0] stack_mem [VALUE_BITS];
  logic [SP_W-1:0]    sp;
  logic [SP_W-1:0]    sp_dec;
  logic               push_en;
  logic [RADIX_W-1:0] push_data;
  logic               issue;
  logic               rd_valid;
  logic               rd_adv;
  logic               rd_last;
  logic [RADIX_W-1:0] rd_data;

  rde_divider #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (radix),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign sp_dec = sp - SP_W'(1);
  assign rd_adv = rd_valid && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) state_next = q_zero ? BK_EMIT : BK_DIV;
      end
      BK_DIV: begin
        if (div_done && div_quot == '0) state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (issue && sp == SP_W'(1)) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop        = 1'b0;
    push_en      = 1'b0;
    push_data    = div_rem;
    div_start    = 1'b0;
    div_dividend = div_quot;
    issue        = 1'b0;
    case (state)
      BK_IDLE: begin
        q_pop        = q_valid;
        div_dividend = q_value;
        if (q_valid && q_zero) begin
          push_en   = 1'b1;
          push_data = '0;
        end else if (q_valid) begin
          div_start = 1'b1;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          push_en   = 1'b1;
          div_start = (div_quot != '0);
        end
      end
      BK_EMIT: begin
        issue = (sp != '0) && (!rd_valid || rd_adv);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (push_en) begin
      sp <= sp + SP_W'(1);
    end else if (issue) begin
      sp <= sp_dec;
    end
  end

  // digit stack, registered read
  always_ff @(posedge clk) begin
    if (push_en) stack_mem[sp[IDX_W-1:0]] <= push_data;
    if (issue) begin
      rd_data <= stack_mem[sp_dec[IDX_W-1:0]];
      rd_last <= (sp == SP_W'(1));
    end
  end

  // read stage and output register valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (rd_adv) begin
        rd_valid <= 1'b0;
      end
      if (rd_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_adv) begin
      digit_char <= digit_to_ascii(rd_data);
      last       <= rd_last;
    end
  end

  `RDE_ASSERT(a_rem_below_radix, !div_done || (div_rem < radix), "divider remainder not below radix")
  `RDE_ASSERT(a_stack_no_overflow, !push_en || (sp < SP_W'(VALUE_BITS)), "digit stack overflow")
  `RDE_ASSERT(a_no_push_while_pop, !(push_en && issue), "digit stack pushed and popped together")
  `RDE_ASSERT_NEXT(a_rd_hold, rd_valid && out_valid && !out_ready, rd_valid && $stable(rd_data), "stalled digit lost")

endmodule

[hdl/radix_digit_emitter.sv]
// Top level of the radix digit emitter: radix register, front end, queue, back end.
// Depends on rde_pkg, rde_front, rde_queue and rde_back.
//
// Converts each accepted value into ASCII digits in the programmed radix, most
// significant digit first, no leading zeros ('0' for zero), last set on the final digit.
// Writes to the radix clamp to 2..36; write it only while the block is idle. The back
// end divides by the radix with a divider that resolves 8 quotient bits a cycle, one
// division per digit, least significant digit first. Digits are then popped from a
// stack one per cycle while out_ready stays high, and the next value may already be
// waiting in the two-entry input queue.
module radix_digit_emitter import rde_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [RADIX_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  digit_char,
  output logic               last
);

  logic [RADIX_W-1:0]    radix;
  logic                  push_valid;
  logic                  push_ready;
  logic [VALUE_BITS-1:0] push_value;
  logic                  push_zero;
  logic                  head_valid;
  logic [VALUE_BITS-1:0] head_value;
  logic                  head_zero;
  logic                  head_pop;

  // radix register, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_wr_data < RADIX_MIN) begin
        radix <= RADIX_MIN;
      end else if (cfg_wr_data > RADIX_MAX) begin
        radix <= RADIX_MAX;
      end else begin
        radix <= cfg_wr_data;
      end
    end
  end

  rde_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_value (push_value),
    .push_zero  (push_zero)
  );

  rde_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_value (push_value),
    .push_zero  (push_zero),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_value (head_value),
    .head_zero  (head_zero)
  );

  rde_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .radix      (radix),
    .q_valid    (head_valid),
    .q_value    (head_value),
    .q_zero     (head_zero),
    .q_pop      (head_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last)
  );

endmodule
